// ===== rtl/core/gen_cepstrum_inverse_gain_norm_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the gain normalization block.
// ----------------------------------------------------------------------------
`ifndef GEN_CEPSTRUM_INVERSE_GAIN_NORM_DEFINES_SVH
`define GEN_CEPSTRUM_INVERSE_GAIN_NORM_DEFINES_SVH

// same-cycle implication
`define GCIGN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GCIGN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/gcign_pkg.sv =====
// ----------------------------------------------------------------------------
// gcign_pkg
// Types, constants and helpers of the cepstrum inverse gain normalization.
// ----------------------------------------------------------------------------
package gcign_pkg;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [3:0] TAYLOR_LAST = 4'd13;
	localparam logic signed [15:0] GAMMA_MAX = 16'sd16384;
	localparam logic signed [15:0] GAMMA_MIN = -16'sd16384;
	localparam logic [7:0] REG_ORDER = 8'd0;
	localparam logic [7:0] REG_GAMMA = 8'd1;
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 16;

	typedef struct packed {
		logic signed [31:0] coeff;
		logic               gain;
		logic               last;
		logic               err;
	} word_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_NORM, ST_SQR, ST_LOGA, ST_LOGB, ST_LOGC, ST_PMUL, ST_PRED,
		ST_TMUL, ST_TDIV, ST_ZSH, ST_QSTART, ST_QDIV, ST_CRND, ST_EMIT
	} back_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

endpackage

// ===== rtl/core/gcign_fifo.sv =====
// ----------------------------------------------------------------------------
// gcign_fifo
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module gcign_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gcign_pkg::word_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output gcign_pkg::word_t head
);

	gcign_pkg::word_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/core/gcign_div.sv =====
// ----------------------------------------------------------------------------
// gcign_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcign_div (
	input  logic                clk,
	input  logic                arst_n,
	input  gcign_pkg::div_req_t req,
	output gcign_pkg::div_rsp_t rsp
);

	localparam int NW = gcign_pkg::DIV_NW;
	localparam int DW = gcign_pkg::DIV_DW;
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign fits    = (shifted >= {1'b0, den_q});

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/gcign_front.sv =====
// ----------------------------------------------------------------------------
// gcign_front
// Accept words, track the frame position and tag gain, last and error.
// ----------------------------------------------------------------------------
module gcign_front #(
	parameter int MAX_ORDER = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] coeff_in,
	input  logic [7:0]         order,
	input  logic               q_full,
	output logic               push,
	output gcign_pkg::word_t   wdata
);

	localparam int IW = $clog2(MAX_ORDER + 1);
	localparam int LW = (IW > 8) ? IW : 8;

	logic [IW-1:0] idx_q;
	logic          frame_error_q;
	logic [LW-1:0] len;
	logic          is_gain;
	logic          last;
	logic          err;

	assign len      = (LW'(order) > LW'(MAX_ORDER)) ? LW'(MAX_ORDER) : LW'(order);
	assign is_gain  = (idx_q == '0);
	assign last     = (LW'(idx_q) >= len);
	assign err      = is_gain ? (coeff_in <= 32'sd0) : frame_error_q;
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign wdata.coeff = coeff_in;
	assign wdata.gain  = is_gain;
	assign wdata.last  = last;
	assign wdata.err   = err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			frame_error_q <= 1'b0;
		end else if (push) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
			if (is_gain) frame_error_q <= err;
		end
	end

endmodule

// ===== rtl/core/gcign_back.sv =====
// ----------------------------------------------------------------------------
// gcign_back
// Execute queued words: log or power of the gain, scaling of coefficients.
// ----------------------------------------------------------------------------
`include "gen_cepstrum_inverse_gain_norm_defines.svh"

module gcign_back #(
	parameter int FRAC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  gamma_cfg,
	input  logic                head_valid,
	input  gcign_pkg::word_t    head,
	output logic                pop,
	output gcign_pkg::div_req_t div_req,
	input  gcign_pkg::div_rsp_t div_rsp,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  coeff_out,
	output logic                frame_last,
	output logic                gain_error
);

	localparam int IPW = 8;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	gcign_pkg::back_state_t state_q, state_d;

	logic [31:0]         m_q;
	logic [4:0]          p_q;
	logic [4:0]          cnt_q;
	logic [31:0]         frac_q;
	logic signed [63:0]  acc_q;
	logic signed [41:0]  t_q;
	logic [29:0]         r_q;
	logic [30:0]         term_q;
	logic [32:0]         sum_q;
	logic [3:0]          k_q;
	logic signed [31:0]  gp_q;
	logic signed [31:0]  res_q;
	logic                neg_q;
	logic                last_q;
	logic                err_q;
	logic                out_valid_q;
	logic signed [31:0]  out_coeff_q;
	logic                out_last_q;
	logic                out_err_q;

	logic signed [15:0]    g;
	logic [15:0]           ad;
	logic                  out_free;
	logic                  emit;
	logic signed [IPW-1:0] ip;
	logic [61:0]           sq;
	logic [31:0]           sqs;
	logic [63:0]           fl;
	logic signed [IPW+32:0] ipl;
	logic signed [47:0]    ln;
	logic signed [63:0]    log_rnd;
	logic signed [39:0]    l2;
	logic signed [55:0]    l2g;
	logic [63:0]           rp;
	logic [60:0]           tp;
	logic signed [9:0]     n;
	logic signed [10:0]    s;
	logic [5:0]            ns;
	logic [39:0]           zr;
	logic signed [31:0]    z;
	logic signed [32:0]    dz;
	logic signed [46:0]    num;
	logic [46:0]           an;
	logic signed [48:0]    qs;
	logic signed [63:0]    c_rnd;
	logic signed [31:0]    c_res;

	assign g = (gamma_cfg > gcign_pkg::GAMMA_MAX) ? gcign_pkg::GAMMA_MAX :
	           (gamma_cfg < gcign_pkg::GAMMA_MIN) ? gcign_pkg::GAMMA_MIN : gamma_cfg;
	assign ad       = g[15] ? 16'(-g) : 16'(g);
	assign out_free = !out_valid_q || out_ready;

	assign ip      = $signed({{(IPW-5){1'b0}}, p_q}) - $signed(IPW'(FRAC_BITS));
	assign sq      = m_q[30:0] * m_q[30:0];
	assign sqs     = sq[61:30];
	assign fl      = 64'(frac_q) * 64'(gcign_pkg::LN2_Q32);
	assign ipl     = ip * $signed({1'b0, gcign_pkg::LN2_Q32});
	assign ln      = 48'(ipl) + $signed({16'b0, acc_q[63:32]});
	assign log_rnd = acc_q + (64'sd1 <<< (31 - FRAC_BITS));
	assign l2      = $signed({ip, frac_q});
	assign l2g     = l2 * g;
	assign rp      = 64'(t_q[31:0]) * 64'(gcign_pkg::LN2_Q32);
	assign tp      = 61'(term_q) * 61'(r_q);
	assign n       = t_q[41:32];
	assign s       = 11'(n) + 11'(FRAC_BITS) - 11'sd30;
	assign ns      = 6'(-s);
	assign zr      = (40'(sum_q) + (40'd1 << (ns - 6'd1))) >> ns;

	always_comb begin
		if (s >= 11'sd1) begin
			z = 32'sh7FFFFFFF;
		end else if (s == 11'sd0) begin
			z = (sum_q > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(sum_q[31:0]);
		end else if (s <= -11'sd40) begin
			z = 32'sd0;
		end else begin
			z = $signed(zr[31:0]);
		end
	end

	assign dz    = 33'(gp_q) - 33'(ONE);
	assign num   = 47'(dz) <<< 14;
	assign an    = num[46] ? 47'(-num) : 47'(num);
	assign qs    = neg_q ? -$signed({1'b0, div_rsp.quotient}) : $signed({1'b0, div_rsp.quotient});
	assign c_rnd = acc_q + (64'sd1 <<< (FRAC_BITS - 1));
	assign c_res = gcign_pkg::sat32(c_rnd >>> FRAC_BITS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gcign_pkg::ST_IDLE: begin
				if (head_valid) begin
					if (!head.gain) state_d = gcign_pkg::ST_CRND;
					else if (head.coeff <= 32'sd0) state_d = gcign_pkg::ST_EMIT;
					else state_d = gcign_pkg::ST_NORM;
				end
			end
			gcign_pkg::ST_NORM: begin
				if (m_q[30] || p_q == 5'd0) state_d = gcign_pkg::ST_SQR;
			end
			gcign_pkg::ST_SQR: begin
				if (cnt_q == 5'd31) begin
					state_d = (g == 16'sd0) ? gcign_pkg::ST_LOGA : gcign_pkg::ST_PMUL;
				end
			end
			gcign_pkg::ST_LOGA:   state_d = gcign_pkg::ST_LOGB;
			gcign_pkg::ST_LOGB:   state_d = gcign_pkg::ST_LOGC;
			gcign_pkg::ST_LOGC:   state_d = gcign_pkg::ST_EMIT;
			gcign_pkg::ST_PMUL:   state_d = gcign_pkg::ST_PRED;
			gcign_pkg::ST_PRED:   state_d = gcign_pkg::ST_TMUL;
			gcign_pkg::ST_TMUL:   state_d = gcign_pkg::ST_TDIV;
			gcign_pkg::ST_TDIV: begin
				if (div_rsp.done) begin
					state_d = (k_q == gcign_pkg::TAYLOR_LAST) ? gcign_pkg::ST_ZSH :
					          gcign_pkg::ST_TMUL;
				end
			end
			gcign_pkg::ST_ZSH:    state_d = gcign_pkg::ST_QSTART;
			gcign_pkg::ST_QSTART: state_d = gcign_pkg::ST_QDIV;
			gcign_pkg::ST_QDIV: begin
				if (div_rsp.done) state_d = gcign_pkg::ST_EMIT;
			end
			gcign_pkg::ST_CRND: begin
				if (out_free) state_d = gcign_pkg::ST_IDLE;
			end
			gcign_pkg::ST_EMIT: begin
				if (out_free) state_d = gcign_pkg::ST_IDLE;
			end
			default: state_d = gcign_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop              = 1'b0;
		emit             = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (state_q)
			gcign_pkg::ST_IDLE: pop = head_valid;
			gcign_pkg::ST_TMUL: begin
				div_req.start    = 1'b1;
				div_req.dividend = gcign_pkg::DIV_NW'(tp[60:30]);
				div_req.divisor  = gcign_pkg::DIV_DW'(k_q);
			end
			gcign_pkg::ST_QSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = gcign_pkg::DIV_NW'(an) + gcign_pkg::DIV_NW'(ad[15:1]);
				div_req.divisor  = ad;
			end
			gcign_pkg::ST_CRND,
			gcign_pkg::ST_EMIT: emit = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gcign_pkg::ST_IDLE;
			gp_q        <= ONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (pop && head.gain && head.coeff <= 32'sd0) gp_q <= ONE;
			if (state_q == gcign_pkg::ST_LOGC) gp_q <= ONE;
			if (state_q == gcign_pkg::ST_ZSH) gp_q <= z;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			gcign_pkg::ST_IDLE: begin
				if (pop) begin
					last_q <= head.last;
					err_q  <= head.err;
					m_q    <= head.coeff;
					p_q    <= 5'd30;
					res_q  <= 32'sd0;
					acc_q  <= head.coeff * gp_q;
				end
			end
			gcign_pkg::ST_NORM: begin
				frac_q <= '0;
				cnt_q  <= '0;
				if (!m_q[30] && p_q != 5'd0) begin
					m_q <= {m_q[30:0], 1'b0};
					p_q <= p_q - 5'd1;
				end
			end
			gcign_pkg::ST_SQR: begin
				m_q    <= sqs[31] ? {1'b0, sqs[31:1]} : sqs;
				frac_q <= {frac_q[30:0], sqs[31]};
				cnt_q  <= cnt_q + 5'd1;
			end
			gcign_pkg::ST_LOGA: acc_q <= $signed(fl);
			gcign_pkg::ST_LOGB: acc_q <= 64'(ln);
			gcign_pkg::ST_LOGC: res_q <= gcign_pkg::sat32(log_rnd >>> (32 - FRAC_BITS));
			gcign_pkg::ST_PMUL: t_q <= l2g[55:14];
			gcign_pkg::ST_PRED: begin
				r_q    <= rp[63:34];
				term_q <= 31'd1 << 30;
				sum_q  <= 33'd1 << 30;
				k_q    <= 4'd1;
			end
			gcign_pkg::ST_TDIV: begin
				if (div_rsp.done) begin
					term_q <= div_rsp.quotient[30:0];
					sum_q  <= sum_q + 33'(div_rsp.quotient[30:0]);
					k_q    <= k_q + 4'd1;
				end
			end
			gcign_pkg::ST_QSTART: neg_q <= (num[46] != g[15]);
			gcign_pkg::ST_QDIV: begin
				if (div_rsp.done) res_q <= gcign_pkg::sat32(64'(qs));
			end
			default: begin
			end
		endcase
		if (emit) begin
			out_coeff_q <= (state_q == gcign_pkg::ST_CRND) ? c_res : res_q;
			out_last_q  <= last_q;
			out_err_q   <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign coeff_out  = out_coeff_q;
	assign frame_last = out_last_q;
	assign gain_error = out_err_q;

	`GCIGN_ASSERT_IMP(a_gp_nonneg, 1'b1, !gp_q[31], "gain power went negative")
	`GCIGN_ASSERT_IMP(a_div_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`GCIGN_ASSERT_IMP(a_emit_free, emit, !out_valid_q || out_ready, "output word overwritten")
	`GCIGN_ASSERT_NXT(a_bad_gain, pop && head.gain && head.coeff <= 32'sd0, gp_q == ONE,
		"bad gain did not reset gain power")

endmodule

// ===== rtl/core/gen_cepstrum_inverse_gain_norm.sv =====
// ----------------------------------------------------------------------------
// gen_cepstrum_inverse_gain_norm
// Inverse gain normalization of generalized cepstral frames, Q8.24 words.
// ----------------------------------------------------------------------------
// A frame is order+1 coefficient words, the first being the gain. Later
// coefficients are multiplied by the gain power, then rounded and saturated
// in the back end. The gain word is iterative: it is normalized by shifting,
// then squared repeatedly to form the log2 fraction bits; log mode then takes
// the LOGA, LOGB and LOGC steps, power mode sums 13 Taylor terms and does a
// final divide, both on the shared bit-serial divider. A two-word queue lets
// input be taken while the back end works; one result word per input word.
module gen_cepstrum_inverse_gain_norm #(
	parameter int MAX_ORDER = 255,
	parameter int FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] coeff_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] coeff_out,
	output logic               frame_last,
	output logic               gain_error
);

	logic [7:0]          order_q;
	logic signed [15:0]  gamma_q;
	logic                q_full;
	logic                push;
	logic                pop;
	logic                head_valid;
	gcign_pkg::word_t    wdata;
	gcign_pkg::word_t    head;
	gcign_pkg::div_req_t div_req;
	gcign_pkg::div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
			gamma_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gcign_pkg::REG_ORDER: order_q <= cfg_data[7:0];
				gcign_pkg::REG_GAMMA: gamma_q <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	gcign_front #(.MAX_ORDER(MAX_ORDER)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.coeff_in (coeff_in),
		.order    (order_q),
		.q_full   (q_full),
		.push     (push),
		.wdata    (wdata)
	);

	gcign_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wdata      (wdata),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	gcign_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	gcign_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gamma_cfg  (gamma_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coeff_out  (coeff_out),
		.frame_last (frame_last),
		.gain_error (gain_error)
	);

endmodule
